[rtl/elliptic_cone_point_generator_macros.svh]
// assertion macros shared by the checker of the cone point generator
`ifndef ELLIPTIC_CONE_POINT_GENERATOR_MACROS_SVH
`define ELLIPTIC_CONE_POINT_GENERATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent, outside reset
`define ECPG_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ecpg check failed: lbl");

// signal must keep its value in the cycle after a stall
`define ECPG_ASSERT_HOLD(lbl, clk, rst, vld, rdy, sig) \
   lbl: assert property (@(posedge clk) disable iff (rst) (vld && !rdy) |=> $stable(sig)) \
      else $error("ecpg stall hold broken: lbl");

// consequent must hold in the cycle after the antecedent, also during reset
`define ECPG_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ecpg next-cycle check failed: lbl");

`endif

[rtl/ecpg_pkg.sv]
// types and constants of the elliptic cone point generator
package ecpg_pkg;

   // angle to phase scale factors, 2^48/(2*pi) and 2^48/360
   localparam logic [45:0] C_RAD = 46'd44798133900177;
   localparam logic [45:0] C_DEG = 46'd781874935307;

   // rotator start value, gain compensation in q2.30
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // largest magnitude of a local x or y
   localparam logic [42:0] LOCAL_MAX = '1;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_TAN_X  = 3'd0,
      REG_TAN_Y  = 3'd1,
      REG_ROW0   = 3'd2,
      REG_ROW1   = 3'd3,
      REG_ROW2   = 3'd4,
      REG_APEX_X = 3'd5,
      REG_APEX_Y = 3'd6,
      REG_APEX_Z = 3'd7
   } reg_index_type;

   // configuration registers as one group
   typedef struct packed {
      logic [31:0]        tan_x;
      logic [31:0]        tan_y;
      logic [53:0]        row0;
      logic [53:0]        row1;
      logic [53:0]        row2;
      logic signed [31:0] apex_x;
      logic signed [31:0] apex_y;
      logic signed [31:0] apex_z;
   } csr_type;

   // data handed from cell to cell along the rotator
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               flip;
      logic signed [31:0] height;
   } cordic_type;

   // cone point in local coordinates
   typedef struct packed {
      logic signed [44:0] px;
      logic signed [44:0] py;
      logic signed [31:0] pz;
      logic               sat;
   } local_type;

   // finished world point
   typedef struct packed {
      logic signed [31:0] wx;
      logic signed [31:0] wy;
      logic signed [31:0] wz;
      logic               sat;
   } world_type;

endpackage

[rtl/ecpg_phase.sv]
// angle to phase conversion and quadrant fold, two pipeline stages
module ecpg_phase (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [31:0]  height,
   input  logic signed [31:0]  angle,
   input  logic                angle_in_degrees,
   output logic                out_valid,
   input  logic                out_ready,
   output ecpg_pkg::cordic_type out_data
);
   import ecpg_pkg::*;

   logic               valid1_ff, valid2_ff;
   logic               ready1, ready2;
   logic [45:0]        scale;
   logic signed [55:0] plo_in, phi_in, plo_ff, phi_ff;
   logic signed [31:0] height_ff;
   logic [63:0]        sum;
   logic [31:0]        phase;
   logic signed [33:0] z;
   cordic_type         data_in, data_ff;

   assign ready2   = !valid2_ff || out_ready;
   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   // split product of angle and scale into two partial products
   always_comb begin
      scale  = angle_in_degrees ? C_DEG : C_RAD;
      plo_in = angle * $signed({1'b0, scale[22:0]});
      phi_in = angle * $signed({1'b0, scale[45:23]});
   end

   // join partial products, round, fold into the right half plane
   always_comb begin
      sum          = 64'(plo_ff) + (64'(phi_ff) << 23) + 64'h0000_0000_8000_0000;
      phase        = sum[63:32];
      z            = {{2{phase[31]}}, phase};
      data_in.flip = 1'b0;
      if (z > 34'sd1073741824) begin
         z            = z - 34'sd2147483648;
         data_in.flip = 1'b1;
      end else if (z < -34'sd1073741824) begin
         z            = z + 34'sd2147483648;
         data_in.flip = 1'b1;
      end
      data_in.x      = CORDIC_GAIN;
      data_in.y      = '0;
      data_in.z      = z;
      data_in.height = height_ff;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= in_valid;
         if (ready2) valid2_ff <= valid1_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         plo_ff    <= plo_in;
         phi_ff    <= phi_in;
         height_ff <= height;
      end
      if (ready2 && valid1_ff) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_data  = data_ff;
endmodule

[rtl/ecpg_cordic_cell.sv]
// one rotation step of the sine and cosine rotator
module ecpg_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ecpg_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ecpg_pkg::cordic_type out_data
);
   import ecpg_pkg::*;

   logic               valid_ff;
   cordic_type         data_in, data_ff;
   logic signed [33:0] xs, ys, zs, dx, dy, step;

   assign in_ready = !valid_ff || out_ready;

   // rotate toward zero residual angle
   always_comb begin
      xs      = in_data.x;
      ys      = in_data.y;
      zs      = in_data.z;
      dx      = ys >>> STAGE;
      dy      = xs >>> STAGE;
      step    = $signed({2'b00, ATAN_TURN[STAGE]});
      data_in = in_data;
      if (!zs[33]) begin
         data_in.x = xs - dx;
         data_in.y = ys + dy;
         data_in.z = zs - step;
      end else begin
         data_in.x = xs + dx;
         data_in.y = ys - dy;
         data_in.z = zs + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

[rtl/ecpg_local.sv]
// scales cosine and sine by tangents and height, three pipeline stages
module ecpg_local (
   input  logic                clock,
   input  logic                reset,
   input  ecpg_pkg::csr_type   csr,
   input  logic                in_valid,
   output logic                in_ready,
   input  ecpg_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ecpg_pkg::local_type out_data
);
   import ecpg_pkg::*;

   logic               valid1_ff, valid2_ff, valid3_ff;
   logic               ready1, ready2, ready3;
   logic signed [33:0] cs, sn, tcs, tsn;
   logic [32:0]        tmx, tmy;
   logic [31:0]        fm;
   logic [63:0]        prx_in, pry_in, prx_ff, pry_ff;
   logic               negx_ff, negy_ff, negx2_ff, negy2_ff;
   logic [31:0]        fm_ff;
   logic signed [31:0] f1_ff, f2_ff;
   logic [63:0]        rx, ry;
   logic [63:0]        mx_in, my_in, mx_ff, my_ff;
   logic [63:0]        qx, qy;
   logic [47:0]        mx, my;
   logic [42:0]        cx, cy;
   local_type          data_in, data_ff;

   assign ready3   = !valid3_ff || out_ready;
   assign ready2   = !valid2_ff || ready3;
   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   // undo the fold, take magnitudes, multiply by the tangents
   always_comb begin
      tcs    = in_data.x;
      tsn    = in_data.y;
      cs     = in_data.flip ? -tcs : tcs;
      sn     = in_data.flip ? -tsn : tsn;
      tmx    = cs[33] ? 33'(-cs) : cs[32:0];
      tmy    = sn[33] ? 33'(-sn) : sn[32:0];
      fm     = in_data.height[31] ? (~in_data.height + 32'd1) : in_data.height;
      prx_in = 64'(csr.tan_x * tmx);
      pry_in = 64'(csr.tan_y * tmy);
   end

   // round off the low 30 bits and multiply by height magnitude
   always_comb begin
      rx    = prx_ff + 64'd536870912;
      ry    = pry_ff + 64'd536870912;
      mx_in = 64'(rx[63:30] * fm_ff);
      my_in = 64'(ry[63:30] * fm_ff);
   end

   // round, clamp and apply sign
   always_comb begin
      qx          = mx_ff + 64'd32768;
      qy          = my_ff + 64'd32768;
      mx          = qx[63:16];
      my          = qy[63:16];
      data_in.sat = 1'b0;
      if (mx > 48'(LOCAL_MAX)) begin
         cx          = LOCAL_MAX;
         data_in.sat = 1'b1;
      end else begin
         cx = mx[42:0];
      end
      if (my > 48'(LOCAL_MAX)) begin
         cy          = LOCAL_MAX;
         data_in.sat = 1'b1;
      end else begin
         cy = my[42:0];
      end
      data_in.px = negx2_ff ? -$signed({2'b00, cx}) : $signed({2'b00, cx});
      data_in.py = negy2_ff ? -$signed({2'b00, cy}) : $signed({2'b00, cy});
      data_in.pz = f2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= in_valid;
         if (ready2) valid2_ff <= valid1_ff;
         if (ready3) valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         prx_ff  <= prx_in;
         pry_ff  <= pry_in;
         negx_ff <= cs[33] ^ in_data.height[31];
         negy_ff <= sn[33] ^ in_data.height[31];
         fm_ff   <= fm;
         f1_ff   <= in_data.height;
      end
      if (ready2 && valid1_ff) begin
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         negx2_ff <= negx_ff;
         negy2_ff <= negy_ff;
         f2_ff    <= f1_ff;
      end
      if (ready3 && valid2_ff) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_data  = data_ff;
endmodule

[rtl/ecpg_world.sv]
// rotation, apex offset and output clamp, two stages ending in the output register
module ecpg_world (
   input  logic               clock,
   input  logic               reset,
   input  ecpg_pkg::csr_type  csr,
   input  logic               in_valid,
   output logic               in_ready,
   input  ecpg_pkg::local_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ecpg_pkg::world_type out_data
);
   import ecpg_pkg::*;

   logic               valid1_ff, valid2_ff;
   logic               ready1, ready2;
   logic [53:0]        rows [3];
   logic signed [44:0] pv [3];
   logic signed [62:0] prod_in [3][3];
   logic signed [62:0] prod_ff [3][3];
   logic               sat1_ff;
   logic signed [31:0] apex [3];
   logic signed [64:0] sum [3];
   logic signed [48:0] sh [3];
   logic signed [49:0] v [3];
   logic signed [31:0] w [3];
   logic               sat2;
   world_type          data_ff;

   assign ready2   = !valid2_ff || out_ready;
   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   // nine coefficient products
   always_comb begin
      rows[0] = csr.row0;
      rows[1] = csr.row1;
      rows[2] = csr.row2;
      pv[0]   = in_data.px;
      pv[1]   = in_data.py;
      pv[2]   = 45'(in_data.pz);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(rows[r][18*c +: 18]) * pv[c];
         end
      end
   end

   // row sums, rounding, apex and clamp
   always_comb begin
      apex[0] = csr.apex_x;
      apex[1] = csr.apex_y;
      apex[2] = csr.apex_z;
      sat2    = sat1_ff;
      for (int r = 0; r < 3; r++) begin
         sum[r] = 65'(prod_ff[r][0]) + 65'(prod_ff[r][1]) + 65'(prod_ff[r][2])
                  + 65'sd32768;
         sh[r]  = 49'(sum[r] >>> 16);
         v[r]   = 50'(sh[r]) + 50'(apex[r]);
         if (v[r] > 50'sd2147483647) begin
            w[r] = 32'h7FFF_FFFF;
            sat2 = 1'b1;
         end else if (v[r] < -50'sd2147483648) begin
            w[r] = 32'h8000_0000;
            sat2 = 1'b1;
         end else begin
            w[r] = v[r][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= in_valid;
         if (ready2) valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         prod_ff <= prod_in;
         sat1_ff <= in_data.sat;
      end
      if (ready2 && valid1_ff) begin
         data_ff.wx  <= w[0];
         data_ff.wy  <= w[1];
         data_ff.wz  <= w[2];
         data_ff.sat <= sat2;
      end
   end

   assign out_valid = valid2_ff;
   assign out_data  = data_ff;
endmodule

[rtl/elliptic_cone_point_generator.sv]
// top level of the elliptic cone point generator
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    tdata: height, angle; tuser: degrees flag
//  rsp      out        rsp_tvalid/tready    tdata: point x, y, z; tuser: saturated
//  csr      in         csr_valid/ready      csr_index, csr_data
//
// one item per cycle while rsp_tready is high; CellCount is SINCOS_STAGES capped at 32, and the
// stages are phase 2, rotator cells CellCount, local scaling 3 and rotation 2, the last rotation
// stage being the output register
// every stage carries a valid bit, so bubbles close up under a stalled output
// and new items enter while a result waits in the output register
// reset clears the valid bits and loads the configuration reset values
module elliptic_cone_point_generator #(
   parameter int SINCOS_STAGES = 18
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // height [31:0], angle [63:32]
   input  logic         req_tuser,   // angle_in_degrees
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
   output logic         rsp_tuser,   // saturated
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [53:0]  csr_data
);
   import ecpg_pkg::*;

   localparam int CellCount = (SINCOS_STAGES > 32) ? 32 : SINCOS_STAGES;

   csr_type    csr_ff;
   logic       cv [CellCount+1];
   logic       cr [CellCount+1];
   cordic_type cd [CellCount+1];
   logic       lv, lr, wr;
   local_type  ld;
   world_type  wd;

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.tan_x  <= 32'd65536;
         csr_ff.tan_y  <= 32'd65536;
         csr_ff.row0   <= 54'd65536;
         csr_ff.row1   <= 54'd17179869184;
         csr_ff.row2   <= 54'd4503599627370496;
         csr_ff.apex_x <= '0;
         csr_ff.apex_y <= '0;
         csr_ff.apex_z <= '0;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_TAN_X:  csr_ff.tan_x  <= csr_data[31:0];
            REG_TAN_Y:  csr_ff.tan_y  <= csr_data[31:0];
            REG_ROW0:   csr_ff.row0   <= csr_data;
            REG_ROW1:   csr_ff.row1   <= csr_data;
            REG_ROW2:   csr_ff.row2   <= csr_data;
            REG_APEX_X: csr_ff.apex_x <= csr_data[31:0];
            REG_APEX_Y: csr_ff.apex_y <= csr_data[31:0];
            REG_APEX_Z: csr_ff.apex_z <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // angle to phase
   ecpg_phase u_phase (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .height           (req_tdata[31:0]),
      .angle            (req_tdata[63:32]),
      .angle_in_degrees (req_tuser),
      .out_valid        (cv[0]),
      .out_ready        (cr[0]),
      .out_data         (cd[0])
   );

   // chain of rotator cells
   for (genvar g = 0; g < CellCount; g++) begin : g_cell
      ecpg_cordic_cell #(.STAGE(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[g]),
         .in_ready  (cr[g]),
         .in_data   (cd[g]),
         .out_valid (cv[g+1]),
         .out_ready (cr[g+1]),
         .out_data  (cd[g+1])
      );
   end

   // local cone coordinates
   ecpg_local u_local (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (cv[CellCount]),
      .in_ready  (cr[CellCount]),
      .in_data   (cd[CellCount]),
      .out_valid (lv),
      .out_ready (lr),
      .out_data  (ld)
   );

   // world coordinates and output register
   ecpg_world u_world (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (lv),
      .in_ready  (lr),
      .in_data   (ld),
      .out_valid (rsp_tvalid),
      .out_ready (wr),
      .out_data  (wd)
   );

   assign wr        = rsp_tready;
   assign rsp_tdata = {wd.wz, wd.wy, wd.wx};
   assign rsp_tuser = wd.sat;
endmodule

[rtl/ecpg_checker.sv]
// port-level checker for the cone point generator, bound to the top level
`include "elliptic_cone_point_generator_macros.svh"

module ecpg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);
   // a stalled result keeps its item
   `ECPG_ASSERT_HOLD(a_rsp_valid_hold, clock, reset, rsp_tvalid, rsp_tready, rsp_tvalid)
   `ECPG_ASSERT_HOLD(a_rsp_data_hold, clock, reset, rsp_tvalid, rsp_tready, {rsp_tuser, rsp_tdata})
   // an empty output stage opens the whole chain to new items
   `ECPG_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   // reset leaves no result behind
   `ECPG_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_tvalid)
endmodule

bind elliptic_cone_point_generator ecpg_checker u_ecpg_checker (.*);
